// ----- rtl/core/ncgs_pkg.sv -----
// Shared types, cell codes and size constants for the grid smoothing block.
`timescale 1ns / 1ps
package ncgs_pkg;

	// Field widths
	localparam int CELL_W = 2;
	localparam int GRID_W = 9;
	localparam int CNT_W  = 4;

	// Grid size limits and reset value
	localparam int              MAX_SIZE_DEF = 256;
	localparam int              MIN_SIZE     = 2;
	localparam logic [GRID_W-1:0] GRID_RESET = 9'd64;

	// Water count at which a cell keeps its code
	localparam int MAJORITY = 4;

	typedef logic [CELL_W-1:0] cell_t;

	// Cell codes
	localparam cell_t CELL_WATER  = 2'd0;
	localparam cell_t CELL_LAND   = 2'd2;
	localparam cell_t CELL_LOCKED = 2'd3;

	// Which neighbors of the cell under update lie inside the grid
	typedef struct packed {
		logic has_up;
		logic has_down;
		logic has_left;
		logic has_right;
	} bounds_t;

endpackage

// ----- rtl/core/ncgs_if.sv -----
// Valid/ready channel interfaces for incoming cells and smoothed results.
`timescale 1ns / 1ps
interface ncgs_in_if;
	import ncgs_pkg::*;

	logic  valid;
	logic  ready;
	cell_t cell_in;
	logic  flush;

	modport source (output valid, output cell_in, output flush, input ready);
	modport sink (input valid, input cell_in, input flush, output ready);
endinterface

interface ncgs_out_if;
	import ncgs_pkg::*;

	logic  valid;
	logic  ready;
	cell_t cell_out;
	logic  last_cell;

	modport source (output valid, output cell_out, output last_cell, input ready);
	modport sink (input valid, input cell_out, input last_cell, output ready);
endinterface

// ----- rtl/core/ncgs_cell.sv -----
// One element of the row delay chain: holds one original and one updated cell code.
`timescale 1ns / 1ps
module ncgs_cell #(
	parameter int CW  = 9,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [CW-1:0]         start_o,
	input  logic [CW-1:0]         start_u,
	input  ncgs_pkg::cell_t       x_new,
	input  ncgs_pkg::cell_t       y_new,
	input  ncgs_pkg::cell_t       prev_o,
	input  ncgs_pkg::cell_t       prev_u,
	output ncgs_pkg::cell_t       orig_q,
	output ncgs_pkg::cell_t       upd_q
);
	import ncgs_pkg::*;

	logic load_o;
	logic load_u;

	// Take the fresh value where the chain entry point sits, else shift from neighbor
	assign load_o = (start_o == CW'(IDX));
	assign load_u = (start_u == CW'(IDX));

	always_ff @(posedge clk) begin
		if (en) begin
			orig_q <= load_o ? x_new : prev_o;
			upd_q  <= load_u ? y_new : prev_u;
		end
	end

endmodule

// ----- rtl/core/ncgs_stencil.sv -----
// 3x3 neighborhood window, water count and smoothing rule for one cell per step.
`timescale 1ns / 1ps
module ncgs_stencil (
	input  logic              clk,
	input  logic              en,
	input  ncgs_pkg::cell_t   x_new,
	input  ncgs_pkg::cell_t   right_x,
	input  ncgs_pkg::cell_t   up_right_y,
	input  ncgs_pkg::bounds_t bnd,
	output ncgs_pkg::cell_t   y_new
);
	import ncgs_pkg::*;

	cell_t cur_q;
	cell_t down_q;
	cell_t down_left_q;
	cell_t up_q;
	cell_t up_left_q;
	cell_t left_q;

	logic [7:0]       water;
	logic [CNT_W-1:0] count;

	// Flag water among in-grid neighbors; row above and left are already updated
	always_comb begin
		water[0] = bnd.has_up   && bnd.has_left  && (up_left_q   == CELL_WATER);
		water[1] = bnd.has_up                    && (up_q        == CELL_WATER);
		water[2] = bnd.has_up   && bnd.has_right && (up_right_y  == CELL_WATER);
		water[3] = bnd.has_left                  && (left_q      == CELL_WATER);
		water[4] = bnd.has_right                 && (right_x     == CELL_WATER);
		water[5] = bnd.has_down && bnd.has_left  && (down_left_q == CELL_WATER);
		water[6] = bnd.has_down                  && (down_q      == CELL_WATER);
		water[7] = bnd.has_down && bnd.has_right && (x_new       == CELL_WATER);
	end

	// Add up the water flags
	always_comb begin
		count = '0;
		for (int b = 0; b < 8; b++) begin
			count = count + CNT_W'(water[b]);
		end
	end

	// Apply the majority rule; locked cells hold
	always_comb begin
		y_new = cur_q;
		if (cur_q != CELL_LOCKED) begin
			if (count < CNT_W'(MAJORITY)) begin
				y_new = CELL_LAND;
			end else if (count > CNT_W'(MAJORITY)) begin
				y_new = CELL_WATER;
			end
		end
	end

	// Advance the window by one column
	always_ff @(posedge clk) begin
		if (en) begin
			cur_q       <= right_x;
			down_left_q <= down_q;
			down_q      <= x_new;
			up_left_q   <= up_q;
			up_q        <= up_right_y;
			left_q      <= y_new;
		end
	end

endmodule

// ----- rtl/core/neighbor_count_grid_smoothing.sv -----
// Top level of the in-place majority smoothing pass over a square grid of cells.
// Throughput: one cell per cycle, limited by the one-step window update, unless stalled.
// Latency: the result for a cell is computed grid_size+1 transfers after the cell's own
// transfer; valid rises from the output register after the input stage, when not stalled.
// Reset: grid_size returns to 64 (clamped to MAX_SIZE) and the pass restarts; the delay
// chain needs no clearing, every value it feeds to the rule is written earlier in the pass.
`timescale 1ns / 1ps
module neighbor_count_grid_smoothing #(
	parameter int MAX_SIZE = ncgs_pkg::MAX_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ncgs_pkg::GRID_W-1:0]   cfg_wdata,
	ncgs_in_if.sink                       in_ch,
	ncgs_out_if.source                    out_ch
);
	import ncgs_pkg::*;

	localparam int DEPTH = MAX_SIZE;
	localparam int CW    = $clog2(MAX_SIZE + 1);
	localparam int EW    = (CW > GRID_W) ? CW : GRID_W;

	// Clamp a written size into the supported range
	function automatic logic [CW-1:0] clamp_size(input logic [GRID_W-1:0] g);
		logic [EW-1:0] ge;
		ge = EW'(g);
		if (ge < EW'(MIN_SIZE)) begin
			return CW'(MIN_SIZE);
		end else if (ge > EW'(MAX_SIZE)) begin
			return CW'(MAX_SIZE);
		end
		return CW'(ge);
	endfunction

	logic [CW-1:0] size_q;
	logic [CW-1:0] size_m1;
	logic [CW-1:0] start_o;
	logic [CW-1:0] start_u;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          emit_q;

	logic          valid_s1;
	cell_t         x_s1;
	logic          move_s1;

	logic          out_valid_q;
	cell_t         cell_q;
	logic          last_q;

	cell_t         y_new;
	cell_t         right_x;
	cell_t         up_right_y;
	bounds_t       bnd;
	logic          is_last;

	cell_t         orig_c [DEPTH];
	cell_t         upd_c  [DEPTH];

	// Grid size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= clamp_size(GRID_RESET);
		end else if (cfg_we) begin
			size_q <= clamp_size(cfg_wdata);
		end
	end

	// Chain entry points: originals delayed by n steps, updated cells by n-1
	assign size_m1 = size_q - CW'(1);
	assign start_o = CW'(MAX_SIZE) - size_q;
	assign start_u = start_o + CW'(1);

	// Step the input stage when the result slot is free or the step yields nothing
	assign move_s1     = valid_s1 && (!emit_q || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			x_s1 <= in_ch.cell_in;
		end
	end

	// Pass position: fill phase first, then row and column of the cell under update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			emit_q <= 1'b0;
		end else if (cfg_we) begin
			fill_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			emit_q <= 1'b0;
		end else if (move_s1) begin
			if (!emit_q) begin
				if (fill_q == size_q) begin
					emit_q <= 1'b1;
					row_q  <= '0;
					col_q  <= '0;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (col_q == size_m1) begin
				col_q <= '0;
				if (row_q == size_m1) begin
					emit_q <= 1'b0;
					fill_q <= '0;
					row_q  <= '0;
				end else begin
					row_q <= row_q + CW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Neighbor presence from the position of the cell under update
	assign bnd.has_up    = (row_q != '0);
	assign bnd.has_down  = (row_q != size_m1);
	assign bnd.has_left  = (col_q != '0);
	assign bnd.has_right = (col_q != size_m1);
	assign is_last       = (row_q == size_m1) && (col_q == size_m1);

	// Row delay chain of cells
	for (genvar c = 0; c < DEPTH; c++) begin : g_chain
		cell_t prev_o;
		cell_t prev_u;
		if (c == 0) begin : g_head
			assign prev_o = x_s1;
			assign prev_u = y_new;
		end else begin : g_body
			assign prev_o = orig_c[c-1];
			assign prev_u = upd_c[c-1];
		end
		ncgs_cell #(
			.CW  (CW),
			.IDX (c)
		) u_cell (
			.clk     (clk),
			.en      (move_s1),
			.start_o (start_o),
			.start_u (start_u),
			.x_new   (x_s1),
			.y_new   (y_new),
			.prev_o  (prev_o),
			.prev_u  (prev_u),
			.orig_q  (orig_c[c]),
			.upd_q   (upd_c[c])
		);
	end

	assign right_x    = orig_c[DEPTH-1];
	assign up_right_y = upd_c[DEPTH-1];

	// Window and smoothing rule
	ncgs_stencil u_stencil (
		.clk        (clk),
		.en         (move_s1),
		.x_new      (x_s1),
		.right_x    (right_x),
		.up_right_y (up_right_y),
		.bnd        (bnd),
		.y_new      (y_new)
	);

	// Output register: load on a result step, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1 && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && emit_q) begin
			cell_q <= y_new;
			last_q <= is_last;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.cell_out  = cell_q;
	assign out_ch.last_cell = last_q;

endmodule
